/* rtl/msc_pkg.sv */
// Shared types, constants and helpers for the cloth force evaluator.
// No dependencies; imported by msc_alu, msc_store and the top level.
package msc_pkg;

  localparam int MAX_SIDE_DEF = 16;
  localparam logic [31:0] ROOT2_Q30 = 32'd1518500250;

  localparam logic [2:0] REG_GRID_SIDE = 3'd0;
  localparam logic [2:0] REG_STIFFNESS = 3'd1;
  localparam logic [2:0] REG_REST_LEN  = 3'd2;
  localparam logic [2:0] REG_MASS      = 3'd3;
  localparam logic [2:0] REG_GRAVITY   = 3'd4;
  localparam logic [2:0] REG_DRAG      = 3'd5;

  localparam logic [1:0] KIND_STRUCT = 2'd0;
  localparam logic [1:0] KIND_SHEAR  = 2'd1;
  localparam logic [1:0] KIND_FLEX   = 2'd2;

  typedef enum logic [1:0] {
    OP_MUL   = 2'd0,
    OP_DIV32 = 2'd1,
    OP_DIV64 = 2'd2,
    OP_SQRT  = 2'd3
  } alu_op_t;

  typedef struct packed {
    logic    go;
    alu_op_t op;
  } alu_req_t;

  typedef struct packed {
    logic signed [2:0] dr;
    logic signed [2:0] dc;
    logic [1:0]        kind;
  } nb_t;

  function automatic nb_t nb_offset(input logic [3:0] k);
    nb_t n;
    case (k)
      4'd0:    n = '{dr:  3'sd0, dc: -3'sd1, kind: KIND_STRUCT};
      4'd1:    n = '{dr:  3'sd0, dc:  3'sd1, kind: KIND_STRUCT};
      4'd2:    n = '{dr: -3'sd1, dc:  3'sd0, kind: KIND_STRUCT};
      4'd3:    n = '{dr:  3'sd1, dc:  3'sd0, kind: KIND_STRUCT};
      4'd4:    n = '{dr: -3'sd1, dc: -3'sd1, kind: KIND_SHEAR};
      4'd5:    n = '{dr: -3'sd1, dc:  3'sd1, kind: KIND_SHEAR};
      4'd6:    n = '{dr:  3'sd1, dc: -3'sd1, kind: KIND_SHEAR};
      4'd7:    n = '{dr:  3'sd1, dc:  3'sd1, kind: KIND_SHEAR};
      4'd8:    n = '{dr:  3'sd0, dc: -3'sd2, kind: KIND_FLEX};
      4'd9:    n = '{dr:  3'sd0, dc:  3'sd2, kind: KIND_FLEX};
      4'd10:   n = '{dr: -3'sd2, dc:  3'sd0, kind: KIND_FLEX};
      4'd11:   n = '{dr:  3'sd2, dc:  3'sd0, kind: KIND_FLEX};
      default: n = '{dr:  3'sd0, dc:  3'sd0, kind: KIND_STRUCT};
    endcase
    return n;
  endfunction

  function automatic logic [31:0] mag32(input logic signed [31:0] v);
    return v[31] ? (~v + 32'd1) : v;
  endfunction

  function automatic logic signed [31:0] sat32(input logic signed [63:0] v);
    if (v > 64'sd2147483647) return 32'sh7FFFFFFF;
    if (v < -64'sd2147483648) return 32'sh80000000;
    return v[31:0];
  endfunction

endpackage

/* rtl/mass_spring_cloth_force_top.sv */
// Cloth grid force evaluator: particle store, sequencer and shared arithmetic unit.
// Depends on msc_pkg, msc_alu and msc_store.
//
// Input words are taken on start while busy is low. A load word (command 0)
// writes one particle into the store in that same edge and leaves busy low.
// An evaluate word (command 1) raises busy until its result word is shown:
// done is high for one cycle with out_row/out_col, the stored velocity and
// the saturated acceleration. Words addressed outside the grid are dropped.
// Pinned top corners show their result straight after the self read.
// Otherwise each in-grid spring takes a neighbor read, three squares and a root
// on the shared unit, then per axis a product, a 32-bit quotient and a stiffness
// product (none if its length is zero); neighbors outside the grid are skipped.
// Drag products and three 64-bit mass quotients follow. A center particle has
// twelve springs.
// Results cannot be held off: done is a one-cycle strobe and the next word
// may be started in the cycle after it.
// Configuration writes use cfg_valid/cfg_ready (ready while idle). Reset
// restores the register defaults and returns to idle; the store is not
// cleared and entries read back as garbage until loaded.
module mass_spring_cloth_force_top #(
  parameter int MAX_SIDE = msc_pkg::MAX_SIDE_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  output logic        busy,
  input  logic        command,
  input  logic [3:0]  row,
  input  logic [3:0]  col,
  input  logic signed [31:0] pos_x,
  input  logic signed [31:0] pos_y,
  input  logic signed [31:0] pos_z,
  input  logic signed [31:0] vel_in_x,
  input  logic signed [31:0] vel_in_y,
  input  logic signed [31:0] vel_in_z,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [2:0]  cfg_index,
  input  logic [31:0] cfg_data,
  output logic        done,
  output logic [3:0]  out_row,
  output logic [3:0]  out_col,
  output logic signed [31:0] deriv_pos_x,
  output logic signed [31:0] deriv_pos_y,
  output logic signed [31:0] deriv_pos_z,
  output logic signed [31:0] accel_x,
  output logic signed [31:0] accel_y,
  output logic signed [31:0] accel_z,
  output logic        pinned
);
  import msc_pkg::*;

  localparam int AW = $clog2(MAX_SIDE * MAX_SIDE);

  typedef enum logic [14:0] {
    S_IDLE  = 15'b000000000000001,
    S_RSELF = 15'b000000000000010,
    S_CAPS  = 15'b000000000000100,
    S_SHEAR = 15'b000000000001000,
    S_NBCHK = 15'b000000000010000,
    S_RNB   = 15'b000000000100000,
    S_CAPN  = 15'b000000001000000,
    S_SQ    = 15'b000000010000000,
    S_SQRT  = 15'b000000100000000,
    S_EMUL  = 15'b000001000000000,
    S_EDIV  = 15'b000010000000000,
    S_KMUL  = 15'b000100000000000,
    S_DRAG  = 15'b001000000000000,
    S_QDIV  = 15'b010000000000000,
    S_OUT   = 15'b100000000000000
  } state_t;

  state_t state;
  logic   issued;

  logic [4:0]  grid_side;
  logic [30:0] stiffness, rest_length, particle_mass, gravity, drag_coefficient;

  logic [3:0]  row_q, col_q;
  logic        pin_q;
  logic [3:0]  k;
  logic [1:0]  c;
  logic signed [31:0] sp [3];
  logic signed [31:0] vel [3];
  logic signed [31:0] dif [3];
  logic signed [53:0] f [3];
  logic signed [31:0] acc [3];
  logic [31:0] rl [3];
  logic [63:0] ss;
  logic [31:0] d;
  logic [31:0] em;
  logic        ext_pos, ext_neg;

  alu_req_t    alu_req;
  logic [63:0] alu_a;
  logic [31:0] alu_b;
  logic [63:0] alu_res;
  logic        alu_done;

  logic          we;
  logic [AW-1:0] waddr, raddr, nb_addr;
  logic [95:0]   rpos, rvel;

  logic [6:0]  side;
  logic        accept, in_grid;
  nb_t         nb;
  logic signed [7:0] nr, nc;
  logic        nb_ok;
  logic [31:0] dm_c, vm_c, t_sat, rl_sel;
  logic signed [33:0] ext;
  logic [53:0] s_abs;
  logic [46:0] s_mag;
  logic signed [53:0] fm, dm16;
  logic signed [63:0] qv;

  always_comb begin
    side    = (32'(grid_side) > MAX_SIDE) ? 7'(MAX_SIDE) : {2'b00, grid_side};
    accept  = start && !busy;
    in_grid = ({3'b000, row} < side) && ({3'b000, col} < side);
    we      = accept && !command && in_grid;
    waddr   = AW'(16'(row) * 16'(MAX_SIDE) + 16'(col));

    nb    = nb_offset(k);
    nr    = $signed({4'b0000, row_q}) + {{5{nb.dr[2]}}, nb.dr};
    nc    = $signed({4'b0000, col_q}) + {{5{nb.dc[2]}}, nb.dc};
    nb_ok = !nr[7] && !nc[7] && (nr < $signed({1'b0, side})) &&
            (nc < $signed({1'b0, side}));
    nb_addr = AW'(16'(nr[6:0]) * 16'(MAX_SIDE) + 16'(nc[6:0]));
    raddr   = (state == S_RNB) ? nb_addr : AW'(16'(row_q) * 16'(MAX_SIDE) + 16'(col_q));

    dm_c   = mag32(dif[c]);
    vm_c   = mag32(vel[c]);
    t_sat  = (|alu_res[63:32]) ? 32'hFFFF_FFFF : alu_res[31:0];
    rl_sel = rl[nb.kind];
    ext    = $signed({2'b00, alu_res[31:0]}) - $signed({2'b00, rl_sel});
    s_abs  = f[c][53] ? 54'(-f[c]) : 54'(f[c]);
    s_mag  = (s_abs > 54'(64'h4000_0000_0000)) ? 47'h4000_0000_0000 : s_abs[46:0];
    fm     = $signed({6'd0, alu_res[63:16]});
    dm16   = $signed({6'd0, alu_res[63:16]});
    qv     = f[c][53] ? -$signed(alu_res) : $signed(alu_res);
    if (c == 2'd1) qv = qv - $signed({33'd0, gravity});

    alu_req.op = OP_MUL;
    alu_a      = '0;
    alu_b      = '0;
    unique case (state)
      S_SHEAR: begin alu_a = {33'd0, rest_length}; alu_b = ROOT2_Q30; end
      S_SQ:    begin alu_a = {32'd0, dm_c}; alu_b = dm_c; end
      S_SQRT:  begin alu_req.op = OP_SQRT; alu_a = ss; end
      S_EMUL:  begin alu_a = {32'd0, em}; alu_b = dm_c; end
      S_EDIV:  begin alu_req.op = OP_DIV32; alu_a = alu_res; alu_b = d; end
      S_KMUL:  begin alu_a = {32'd0, t_sat}; alu_b = {1'b0, stiffness}; end
      S_DRAG:  begin alu_a = {32'd0, vm_c}; alu_b = {1'b0, drag_coefficient}; end
      S_QDIV: begin
        alu_req.op = OP_DIV64;
        alu_a      = {1'b0, s_mag, 16'd0};
        alu_b      = (particle_mass == '0) ? 32'd1 : {1'b0, particle_mass};
      end
      default: ;
    endcase
    alu_req.go = !issued && ((state == S_SHEAR) || (state == S_SQ) ||
                 (state == S_SQRT) || (state == S_EMUL) || (state == S_EDIV) ||
                 (state == S_KMUL) || (state == S_DRAG) || (state == S_QDIV));
  end

  assign busy      = (state != S_IDLE);
  assign cfg_ready = !busy;
  assign done      = (state == S_OUT);

  always_ff @(posedge clk) begin
    if (rst) begin
      grid_side        <= 5'd16;
      stiffness        <= 31'd655360;
      rest_length      <= 31'd16384;
      particle_mass    <= 31'd65536;
      gravity          <= 31'd642253;
      drag_coefficient <= 31'd32768;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        REG_GRID_SIDE: grid_side        <= cfg_data[4:0];
        REG_STIFFNESS: stiffness        <= cfg_data[30:0];
        REG_REST_LEN:  rest_length      <= cfg_data[30:0];
        REG_MASS:      particle_mass    <= cfg_data[30:0];
        REG_GRAVITY:   gravity          <= cfg_data[30:0];
        REG_DRAG:      drag_coefficient <= cfg_data[30:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state  <= S_IDLE;
      issued <= 1'b0;
    end else begin
      if (alu_req.go) issued <= 1'b1;
      else if (alu_done) issued <= 1'b0;
      unique case (state)
        S_IDLE: begin
          if (accept && command && in_grid) begin
            row_q <= row;
            col_q <= col;
            pin_q <= (row == 4'd0) && ((col == 4'd0) || ({3'b000, col} == side - 7'd1));
            state <= S_RSELF;
          end
        end
        S_RSELF: state <= S_CAPS;
        S_CAPS: begin
          sp[0]  <= rpos[95:64];
          sp[1]  <= rpos[63:32];
          sp[2]  <= rpos[31:0];
          vel[0] <= rvel[95:64];
          vel[1] <= rvel[63:32];
          vel[2] <= rvel[31:0];
          for (int i = 0; i < 3; i++) begin
            acc[i] <= '0;
            f[i]   <= '0;
          end
          k     <= '0;
          state <= pin_q ? S_OUT : S_SHEAR;
        end
        S_SHEAR: begin
          if (alu_done) begin
            rl[0] <= {1'b0, rest_length};
            rl[1] <= 32'((alu_res + 64'h2000_0000) >> 30);
            rl[2] <= {rest_length, 1'b0};
            state <= S_NBCHK;
          end
        end
        S_NBCHK: begin
          if (nb_ok) state <= S_RNB;
          else if (k == 4'd11) begin state <= S_DRAG; c <= '0; end
          else k <= k + 4'd1;
        end
        S_RNB: state <= S_CAPN;
        S_CAPN: begin
          dif[0] <= sat32(64'(sp[0]) - 64'($signed(rpos[95:64])));
          dif[1] <= sat32(64'(sp[1]) - 64'($signed(rpos[63:32])));
          dif[2] <= sat32(64'(sp[2]) - 64'($signed(rpos[31:0])));
          ss     <= '0;
          c      <= '0;
          state  <= S_SQ;
        end
        S_SQ: begin
          if (alu_done) begin
            ss <= ss + alu_res;
            if (c == 2'd2) begin c <= '0; state <= S_SQRT; end
            else c <= c + 2'd1;
          end
        end
        S_SQRT: begin
          if (alu_done) begin
            d       <= alu_res[31:0];
            ext_pos <= !ext[33] && (|ext);
            ext_neg <= ext[33];
            em      <= ext[33] ? 32'(-ext) : ext[31:0];
            if (alu_res[31:0] != 32'd0) state <= S_EMUL;
            else if (k == 4'd11) begin state <= S_DRAG; c <= '0; end
            else begin k <= k + 4'd1; state <= S_NBCHK; end
          end
        end
        S_EMUL: if (alu_done) state <= S_EDIV;
        S_EDIV: if (alu_done) state <= S_KMUL;
        S_KMUL: begin
          if (alu_done) begin
            if ((ext_pos && !dif[c][31] && (|dif[c])) || (ext_neg && dif[c][31]))
              f[c] <= f[c] - fm;
            else
              f[c] <= f[c] + fm;
            if (c != 2'd2) begin c <= c + 2'd1; state <= S_EMUL; end
            else if (k == 4'd11) begin c <= '0; state <= S_DRAG; end
            else begin k <= k + 4'd1; state <= S_NBCHK; end
          end
        end
        S_DRAG: begin
          if (alu_done) begin
            f[c] <= vel[c][31] ? (f[c] + dm16) : (f[c] - dm16);
            if (c == 2'd2) begin c <= '0; state <= S_QDIV; end
            else c <= c + 2'd1;
          end
        end
        S_QDIV: begin
          if (alu_done) begin
            acc[c] <= sat32(qv);
            if (c == 2'd2) state <= S_OUT;
            else c <= c + 2'd1;
          end
        end
        S_OUT: state <= S_IDLE;
        default: state <= S_IDLE;
      endcase
    end
  end

  assign out_row     = row_q;
  assign out_col     = col_q;
  assign pinned      = pin_q;
  assign deriv_pos_x = vel[0];
  assign deriv_pos_y = vel[1];
  assign deriv_pos_z = vel[2];
  assign accel_x     = acc[0];
  assign accel_y     = acc[1];
  assign accel_z     = acc[2];

  msc_alu u_alu (
    .clk  (clk),
    .rst  (rst),
    .req  (alu_req),
    .a    (alu_a),
    .b    (alu_b),
    .res  (alu_res),
    .done (alu_done)
  );

  msc_store #(
    .MAX_SIDE (MAX_SIDE),
    .AW       (AW)
  ) u_store (
    .clk   (clk),
    .we    (we),
    .waddr (waddr),
    .wpos  ({pos_x, pos_y, pos_z}),
    .wvel  ({vel_in_x, vel_in_y, vel_in_z}),
    .raddr (raddr),
    .rpos  (rpos),
    .rvel  (rvel)
  );

  a_done_then_idle: assert property (@(posedge clk) disable iff (rst) done |=> !busy)
    else $error("result word not followed by idle");
  a_alu_only_busy: assert property (@(posedge clk) disable iff (rst) alu_req.go |-> busy)
    else $error("arithmetic unit started while idle");
  a_nb_in_grid: assert property (@(posedge clk) disable iff (rst)
    (state == S_RNB) |-> nb_ok)
    else $error("neighbor read outside grid");

endmodule

/* rtl/msc_alu.sv */
// Shared arithmetic unit: 32x32 multiply, bit-serial divide and square root.
// Depends on msc_pkg (alu_req_t, alu_op_t).
module msc_alu (
  input  logic              clk,
  input  logic              rst,
  input  msc_pkg::alu_req_t req,
  input  logic [63:0]       a,
  input  logic [31:0]       b,
  output logic [63:0]       res,
  output logic              done
);
  import msc_pkg::*;

  alu_op_t     op_q;
  logic        run;
  logic [6:0]  cnt;
  logic [63:0] n;
  logic [32:0] rem;
  logic [31:0] dv;
  logic [63:0] r;
  logic [63:0] bb;

  logic [32:0] rem2;
  logic        ge;
  logic [32:0] rem_next;
  logic [63:0] n_next;
  logic [63:0] r_next;
  logic [63:0] sq_t;

  always_comb begin
    rem2     = {rem[31:0], n[63]};
    ge       = rem2 >= {1'b0, dv};
    rem_next = ge ? (rem2 - {1'b0, dv}) : rem2;
    sq_t     = r + bb;
    if (op_q == OP_SQRT) begin
      if (n >= sq_t) begin
        n_next = n - sq_t;
        r_next = (r >> 1) + bb;
      end else begin
        n_next = n;
        r_next = r >> 1;
      end
    end else begin
      n_next = {n[62:0], ge};
      r_next = r;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      run  <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
      op_q <= OP_MUL;
    end else begin
      done <= 1'b0;
      if (req.go) begin
        op_q <= req.op;
        dv   <= b;
        unique case (req.op)
          OP_MUL: begin
            res  <= a[31:0] * b;
            done <= 1'b1;
          end
          OP_DIV32: begin
            rem <= {1'b0, a[63:32]};
            n   <= {a[31:0], 32'd0};
            cnt <= 7'd32;
            run <= 1'b1;
          end
          OP_DIV64: begin
            rem <= '0;
            n   <= a;
            cnt <= 7'd64;
            run <= 1'b1;
          end
          OP_SQRT: begin
            n   <= a;
            r   <= '0;
            bb  <= 64'h4000_0000_0000_0000;
            cnt <= 7'd32;
            run <= 1'b1;
          end
          default: ;
        endcase
      end else if (run) begin
        rem <= rem_next;
        n   <= n_next;
        r   <= r_next;
        bb  <= bb >> 2;
        cnt <= cnt - 7'd1;
        if (cnt == 7'd1) begin
          run  <= 1'b0;
          done <= 1'b1;
          res  <= (op_q == OP_SQRT) ? r_next : n_next;
        end
      end
    end
  end

endmodule

/* rtl/msc_store.sv */
// Particle state memory: position and velocity words, one write, one read port.
// Depends on msc_pkg for the default grid size.
module msc_store #(
  parameter int MAX_SIDE = msc_pkg::MAX_SIDE_DEF,
  parameter int AW       = $clog2(MAX_SIDE * MAX_SIDE)
) (
  input  logic          clk,
  input  logic          we,
  input  logic [AW-1:0] waddr,
  input  logic [95:0]   wpos,
  input  logic [95:0]   wvel,
  input  logic [AW-1:0] raddr,
  output logic [95:0]   rpos,
  output logic [95:0]   rvel
);
  import msc_pkg::*;

  localparam int DEPTH = MAX_SIDE * MAX_SIDE;

  logic [95:0] pos_mem [DEPTH];
  logic [95:0] vel_mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      pos_mem[waddr] <= wpos;
      vel_mem[waddr] <= wvel;
    end
    rpos <= pos_mem[raddr];
    rvel <= vel_mem[raddr];
  end

endmodule
